>>> hw/rtl/dwvs_pkg.sv
// ============================================================================
// dwvs_pkg
// Shared types, constants and tables of the dynamic window velocity select.
// ============================================================================
`default_nettype none

package dwvs_pkg;

    localparam int SAMPLES_PER_AXIS_DEF = 3;
    localparam int CORDIC_STEPS_DEF     = 16;
    localparam int CORDIC_STEPS_MAX     = 24;

    localparam int LIN_STEP   = 9830;   // 0.6 m/s^2 * 0.5 s, Q1.15
    localparam int ANG_STEP   = 26214;  // 1.6 rad/s^2 * 0.5 s, Q1.15
    localparam int PI_Q13     = 25736;
    localparam int TWO_PI_Q13 = 51472;
    localparam logic signed [32:0] HALF_PI_Z = 33'sd843314857;

    localparam logic [14:0] MAX_LIN_RST  = 15'd18022;
    localparam logic [14:0] MAX_TURN_RST = 15'd26214;

    localparam int CFG_IDX_W = 8;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_LINEAR = 8'd0,
        CFG_MAX_TURN   = 8'd1
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [15:0] pose_heading;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic        [31:0] obstacle_range;
        logic signed [15:0] cur_linear;
        logic signed [15:0] cur_angular;
    } in_beat_t;

    typedef struct packed {
        logic        [14:0] cmd_linear;
        logic signed [15:0] cmd_angular;
        logic               found;
    } out_beat_t;

    // atan(2^-i) in units of 2^-29 rad
    function automatic logic signed [32:0] atan_z(input int i);
        logic signed [32:0] r;
        unique case (i)
            0:  r = 33'sd421657428;
            1:  r = 33'sd248918915;
            2:  r = 33'sd131521918;
            3:  r = 33'sd66762579;
            4:  r = 33'sd33510843;
            5:  r = 33'sd16771758;
            6:  r = 33'sd8387925;
            7:  r = 33'sd4194219;
            8:  r = 33'sd2097141;
            9:  r = 33'sd1048575;
            10: r = 33'sd524288;
            11: r = 33'sd262144;
            12: r = 33'sd131072;
            13: r = 33'sd65536;
            14: r = 33'sd32768;
            15: r = 33'sd16384;
            16: r = 33'sd8192;
            17: r = 33'sd4096;
            18: r = 33'sd2048;
            19: r = 33'sd1024;
            20: r = 33'sd512;
            21: r = 33'sd256;
            22: r = 33'sd128;
            23: r = 33'sd64;
            default: r = 33'sd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dwvs_window.sv
// ============================================================================
// dwvs_window
// Velocity windows, evenly spaced samples and braking-distance check.
// ============================================================================
`default_nettype none

module dwvs_window #(
    parameter int N   = dwvs_pkg::SAMPLES_PER_AXIS_DEF,
    parameter int DLY = 13
) (
    input  wire                        clk,
    input  wire                        en,
    input  dwvs_pkg::in_beat_t         in_data,
    input  wire  [14:0]                max_lin,
    input  wire  [14:0]                max_turn,
    output logic [14:0]                v_o [N],
    output logic signed [15:0]         w_o [N],
    output logic [N-1:0]               ok_o,
    output logic signed [15:0]         heading_o
);

    localparam logic [24:0] RECIP = 25'((2**24 + N - 2) / (N - 1));
    localparam logic [19:0] RECIP3 = 20'd349526;  // ceil(2^20 / 3)
    localparam int FW = N * 31 + N + 16;

    // stage 1: windows
    logic [14:0]        vlo_reg, vspan_reg;
    logic signed [15:0] wlo_reg;
    logic [15:0]        wspan_reg;
    logic [31:0]        range_reg [5];
    logic signed [15:0] head_reg [5];

    logic signed [17:0] vl, vh, wl, wh, vmx, wmx;

    always_comb
    begin
        vmx = {3'b000, max_lin};
        wmx = {3'b000, max_turn};
        vl  = 18'(in_data.cur_linear) - 18'sd9830;
        vh  = 18'(in_data.cur_linear) + 18'sd9830;
        wl  = 18'(in_data.cur_angular) - 18'sd26214;
        wh  = 18'(in_data.cur_angular) + 18'sd26214;
        if (vl < 0) vl = '0; else if (vl > vmx) vl = vmx;
        if (vh < 0) vh = '0; else if (vh > vmx) vh = vmx;
        if (wl < -wmx) wl = -wmx; else if (wl > wmx) wl = wmx;
        if (wh < -wmx) wh = -wmx; else if (wh > wmx) wh = wmx;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vlo_reg      <= vl[14:0];
            vspan_reg    <= 15'(vh - vl);
            wlo_reg      <= wl[15:0];
            wspan_reg    <= 16'(wh - wl);
            range_reg[0] <= in_data.obstacle_range;
            head_reg[0]  <= in_data.pose_heading;
            for (int k = 1; k < 5; k++)
            begin
                range_reg[k] <= range_reg[k-1];
                head_reg[k]  <= head_reg[k-1];
            end
        end
    end

    // stages 2..6: per-sample lanes
    logic [18:0]        pv_reg [N], pw_reg [N];
    logic [14:0]        vlo2_reg;
    logic signed [15:0] wlo2_reg;
    logic [14:0]        v3_reg [N], v4_reg [N], v5_reg [N];
    logic signed [15:0] w3_reg [N], w4_reg [N], w5_reg [N];
    logic [29:0]        sq_reg [N];
    logic [16:0]        t_reg [N];
    logic [N-1:0]       ok_reg;

    for (genvar i = 0; i < N; i++) begin : g_lane
        logic [43:0] prod_v, prod_w;
        logic [15:0] qv, qw;
        logic [32:0] five_sq;
        logic [37:0] prod_t;
        logic [17:0] need;

        assign prod_v  = 44'(pv_reg[i]) * 44'(RECIP);
        assign prod_w  = 44'(pw_reg[i]) * 44'(RECIP);
        assign qv      = prod_v[39:24];
        assign qw      = prod_w[39:24];
        assign five_sq = 33'(sq_reg[i]) * 33'd5;
        assign prod_t  = 38'(five_sq[32:15]) * 38'(RECIP3);
        assign need    = 18'(t_reg[i]) + 18'(v5_reg[i]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pv_reg[i] <= 19'(vspan_reg) * 19'(i);
                pw_reg[i] <= 19'(wspan_reg) * 19'(i);
                v3_reg[i] <= vlo2_reg + qv[14:0];
                w3_reg[i] <= 16'(17'(wlo2_reg) + 17'({1'b0, qw}));
                sq_reg[i] <= 30'(v3_reg[i]) * 30'(v3_reg[i]);
                v4_reg[i] <= v3_reg[i];
                w4_reg[i] <= w3_reg[i];
                t_reg[i]  <= prod_t[36:20];
                v5_reg[i] <= v4_reg[i];
                w5_reg[i] <= w4_reg[i];
                ok_reg[i] <= {14'd0, need} < range_reg[4];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vlo2_reg <= vlo_reg;
            wlo2_reg <= wlo_reg;
        end
    end

    // stage 6 outputs packed and delayed to line up with the bearing
    logic [FW-1:0] flat;
    logic [FW-1:0] dly_in;
    logic [FW-1:0] dly_reg [1:DLY];

    always_comb
    begin
        flat = '0;
        for (int i = 0; i < N; i++)
        begin
            flat[i*31 +: 15]      = v5_reg[i];
            flat[i*31 + 15 +: 16] = w5_reg[i];
        end
        flat[N*31 +: N]      = ok_reg;
        flat[N*32 +: 16]     = head_reg[4];
    end

    // ok_reg sits one stage after v5/w5 and head_reg[4]: delay those once more
    logic [FW-1:0] vw_hold_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vw_hold_reg <= flat;
        end
    end

    always_comb
    begin
        dly_in = vw_hold_reg;
        dly_in[N*31 +: N] = ok_reg;
    end

    for (genvar k = 1; k <= DLY; k++) begin : g_dly
        if (k == 1) begin : g_first
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dly_reg[k] <= dly_in;
                end
            end
        end
        else begin : g_next
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dly_reg[k] <= dly_reg[k-1];
                end
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_out
        assign v_o[i] = dly_reg[DLY][i*31 +: 15];
        assign w_o[i] = dly_reg[DLY][i*31 + 15 +: 16];
    end
    assign ok_o      = dly_reg[DLY][N*31 +: N];
    assign heading_o = dly_reg[DLY][N*32 +: 16];

endmodule

`default_nettype wire

>>> hw/rtl/dwvs_cordic.sv
// ============================================================================
// dwvs_cordic
// Pipelined vectoring CORDIC giving the goal bearing in Q3.13 radians.
// ============================================================================
`default_nettype none

module dwvs_cordic #(
    parameter int STEPS = dwvs_pkg::CORDIC_STEPS_DEF
) (
    input  wire                    clk,
    input  wire                    en,
    input  dwvs_pkg::in_beat_t     in_data,
    output logic signed [16:0]     bearing
);

    localparam int XW = 36;

    logic signed [32:0] dx_reg, dy_reg;
    logic               zero_reg [STEPS+2];
    logic signed [XW-1:0] x_reg [STEPS+1];
    logic signed [XW-1:0] y_reg [STEPS+1];
    logic signed [32:0]   z_reg [STEPS+1];
    logic signed [32:0]   dx_n, dy_n;

    assign dx_n = 33'(in_data.goal_x) - 33'(in_data.pose_x);
    assign dy_n = 33'(in_data.goal_y) - 33'(in_data.pose_y);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg      <= dx_n;
            dy_reg      <= dy_n;
            zero_reg[0] <= (dx_n == 0) && (dy_n == 0);
        end
    end

    // quadrant pre-rotation for the left half plane
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[1] <= zero_reg[0];
            if (dx_reg < 0)
            begin
                if (dy_reg >= 0)
                begin
                    x_reg[0] <= XW'(dy_reg);
                    y_reg[0] <= -XW'(dx_reg);
                    z_reg[0] <= dwvs_pkg::HALF_PI_Z;
                end
                else
                begin
                    x_reg[0] <= -XW'(dy_reg);
                    y_reg[0] <= XW'(dx_reg);
                    z_reg[0] <= -dwvs_pkg::HALF_PI_Z;
                end
            end
            else
            begin
                x_reg[0] <= XW'(dx_reg);
                y_reg[0] <= XW'(dy_reg);
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        localparam logic signed [32:0] ANG = dwvs_pkg::atan_z(k - 1);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[k+1] <= zero_reg[k];
                if (y_reg[k-1] >= 0)
                begin
                    x_reg[k] <= x_reg[k-1] + (y_reg[k-1] >>> (k - 1));
                    y_reg[k] <= y_reg[k-1] - (x_reg[k-1] >>> (k - 1));
                    z_reg[k] <= z_reg[k-1] + ANG;
                end
                else
                begin
                    x_reg[k] <= x_reg[k-1] - (y_reg[k-1] >>> (k - 1));
                    y_reg[k] <= y_reg[k-1] + (x_reg[k-1] >>> (k - 1));
                    z_reg[k] <= z_reg[k-1] - ANG;
                end
            end
        end
    end

    logic signed [33:0] zr;
    assign zr = 34'(z_reg[STEPS]) + 34'sd32768;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bearing <= zero_reg[STEPS+1] ? 17'sd0 : zr[32:16];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/dwvs_score.sv
// ============================================================================
// dwvs_score
// Heading error per turn sample, best turn, best surviving forward speed.
// ============================================================================
`default_nettype none

module dwvs_score #(
    parameter int N = dwvs_pkg::SAMPLES_PER_AXIS_DEF
) (
    input  wire                        clk,
    input  wire                        en,
    input  wire signed [16:0]          bearing,
    input  wire signed [15:0]          heading,
    input  wire  [14:0]                v_i [N],
    input  wire signed [15:0]          w_i [N],
    input  wire  [N-1:0]               ok_i,
    output dwvs_pkg::out_beat_t        out_data
);

    // stage 1: wrapped absolute error per turn sample
    logic [15:0]        err_reg [N];
    logic signed [15:0] w1_reg [N];
    logic [14:0]        v1_reg [N];
    logic [N-1:0]       ok1_reg;

    for (genvar j = 0; j < N; j++) begin : g_err
        logic signed [18:0] e;
        always_comb
        begin
            e = 19'(bearing) - 19'(heading) - 19'(w_i[j] >>> 3);
            if (e > 19'(dwvs_pkg::PI_Q13))
                e = e - 19'(dwvs_pkg::TWO_PI_Q13);
            else if (e < -19'(dwvs_pkg::PI_Q13))
                e = e + 19'(dwvs_pkg::TWO_PI_Q13);
            if (e < 0)
                e = -e;
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                err_reg[j] <= e[15:0];
                w1_reg[j]  <= w_i[j];
                v1_reg[j]  <= v_i[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok1_reg <= ok_i;
        end
    end

    // stage 2: the turn with the least error wins in every row (first one)
    logic signed [15:0] wb_reg;
    logic [14:0]        v2_reg [N];
    logic [N-1:0]       ok2_reg;
    logic [15:0]        emin;
    logic signed [15:0] wsel;

    always_comb
    begin
        emin = err_reg[0];
        wsel = w1_reg[0];
        for (int j = 1; j < N; j++)
        begin
            if (err_reg[j] < emin)
            begin
                emin = err_reg[j];
                wsel = w1_reg[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wb_reg  <= wsel;
            v2_reg  <= v1_reg;
            ok2_reg <= ok1_reg;
        end
    end

    // stage 3: rows share the error term, so the fastest surviving row wins
    logic        any;
    logic [14:0] vsel;

    always_comb
    begin
        any  = 1'b0;
        vsel = '0;
        for (int i = 0; i < N; i++)
        begin
            if (ok2_reg[i] && (!any || v2_reg[i] > vsel))
            begin
                any  = 1'b1;
                vsel = v2_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data.cmd_linear  <= vsel;
            out_data.cmd_angular <= any ? wb_reg : 16'sd0;
            out_data.found       <= any;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/dynamic_window_velocity_select.sv
// ============================================================================
// dynamic_window_velocity_select
// Picks forward speed and turn rate from a sampled dynamic window.
// ============================================================================
// Use: one input beat per command cycle carries pose, goal, obstacle range
// and current speeds; one output beat returns the chosen speeds and found.
// Channels are valid/ready. The config port (cfg_we, cfg_addr, cfg_data)
// sets the speed limits; write it only while nothing is in flight.
// Pipeline: input beat to output beat through the pipelined CORDIC (input,
// pre-rotation, one stage per micro-rotation, rounding), then the error,
// best turn and best speed stages.
// Throughput: one beat per cycle while the receiver does not stall, set by
// the single-stage-per-step CORDIC. The window and sample lanes run
// alongside the CORDIC and are delayed to meet the bearing.
// Reset clears the valid bits of the pipeline and loads the default limits.
// When the receiver stalls, the whole pipeline holds in place and in_ready
// drops; nothing is lost or repeated.
// ============================================================================
`default_nettype none

module dynamic_window_velocity_select #(
    parameter int SAMPLES_PER_AXIS = dwvs_pkg::SAMPLES_PER_AXIS_DEF,
    parameter int CORDIC_STEPS     = dwvs_pkg::CORDIC_STEPS_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  dwvs_pkg::in_beat_t               in_data,
    output logic                             out_valid,
    input  wire                              out_ready,
    output dwvs_pkg::out_beat_t              out_data,
    input  wire                              cfg_we,
    input  wire  [dwvs_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire  [14:0]                      cfg_data
);

    localparam int CLAT = CORDIC_STEPS + 3;   // bearing latency
    localparam int LAT  = CLAT + 3;           // total latency

    logic [14:0] max_lin_reg, max_turn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_lin_reg  <= dwvs_pkg::MAX_LIN_RST;
            max_turn_reg <= dwvs_pkg::MAX_TURN_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == dwvs_pkg::CFG_MAX_LINEAR)
                max_lin_reg <= cfg_data;
            else if (cfg_addr == dwvs_pkg::CFG_MAX_TURN)
                max_turn_reg <= cfg_data;
        end
    end

    // global advance: the output register frees up or is empty
    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    logic [LAT-1:0] vpipe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vpipe_reg <= '0;
        else if (en)
            vpipe_reg <= {vpipe_reg[LAT-2:0], in_valid};
    end

    assign out_valid = vpipe_reg[LAT-1];

    logic [14:0]        v_s [SAMPLES_PER_AXIS];
    logic signed [15:0] w_s [SAMPLES_PER_AXIS];
    logic [SAMPLES_PER_AXIS-1:0] ok_s;
    logic signed [15:0] head_s;
    logic signed [16:0] bearing;

    // window lanes take 6 stages before the delay line
    dwvs_window #(
        .N   (SAMPLES_PER_AXIS),
        .DLY (CLAT - 6)
    ) u_window (
        .clk       (clk),
        .en        (en),
        .in_data   (in_data),
        .max_lin   (max_lin_reg),
        .max_turn  (max_turn_reg),
        .v_o       (v_s),
        .w_o       (w_s),
        .ok_o      (ok_s),
        .heading_o (head_s)
    );

    dwvs_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .en      (en),
        .in_data (in_data),
        .bearing (bearing)
    );

    dwvs_score #(
        .N (SAMPLES_PER_AXIS)
    ) u_score (
        .clk      (clk),
        .en       (en),
        .bearing  (bearing),
        .heading  (head_s),
        .v_i      (v_s),
        .w_i      (w_s),
        .ok_i     (ok_s),
        .out_data (out_data)
    );

    a_nofind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |->
            (out_data.cmd_linear == 15'd0) && (out_data.cmd_angular == 16'sd0))
        else $error("no sample found but command not zero");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(vpipe_reg))
        else $error("pipeline moved during stall");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

endmodule

`default_nettype wire

>>> bench/dwvs_checker.sv
// ----------------------------------------------------------------------------
// dwvs_checker
// Watches both channels of the velocity selector, predicts each command from
// the accepted input beat and the current speed limits, and compares in order.
// ----------------------------------------------------------------------------
module dwvs_checker
    import dwvs_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    input  wire        in_ready,
    input  in_beat_t   in_data,
    input  wire        out_valid,
    input  wire        out_ready,
    input  out_beat_t  out_data,
    input  wire        cfg_we,
    input  wire  [CFG_IDX_W-1:0] cfg_addr,
    input  wire  [14:0] cfg_data,
    output int         errors,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSAMP = SAMPLES_PER_AXIS_DEF;
    localparam int NSTEP = CORDIC_STEPS_DEF;

    logic [14:0] lin_limit;
    logic [14:0] turn_limit;
    out_beat_t   cmd_q[$];

    function automatic longint fdiv2(longint v, int s);
        if (v >= 0) return v >>> s;
        return -((-v - 1) >>> s) - 1;
    endfunction

    function automatic int clampi(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int goal_bearing(longint dx, longint dy);
        longint x, y, z, t, xs, ys;
        longint tab[24];
        x = dx; y = dy; z = 0;
        tab = '{421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
                8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072,
                65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64};
        if (dx == 0 && dy == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = 843314857;
            end
            else
            begin
                x = -y; y = t; z = -843314857;
            end
        end
        for (int i = 0; i < NSTEP; i++)
        begin
            xs = fdiv2(x, i);
            ys = fdiv2(y, i);
            if (y >= 0)
            begin
                x = x + ys; y = y - xs; z += tab[i];
            end
            else
            begin
                x = x - ys; y = y + xs; z -= tab[i];
            end
        end
        return int'(fdiv2(z + 32768, 16));
    endfunction

    function automatic out_beat_t pick_command(in_beat_t b);
        int vlo, vhi, wlo, whi, dir, v, w, err;
        longint score, best, need;
        bit hit;
        out_beat_t r;
        vlo = clampi(int'(b.cur_linear) - LIN_STEP, 0, int'(lin_limit));
        vhi = clampi(int'(b.cur_linear) + LIN_STEP, 0, int'(lin_limit));
        wlo = clampi(int'(b.cur_angular) - ANG_STEP, -int'(turn_limit), int'(turn_limit));
        whi = clampi(int'(b.cur_angular) + ANG_STEP, -int'(turn_limit), int'(turn_limit));
        dir = goal_bearing(longint'(b.goal_x) - longint'(b.pose_x),
                           longint'(b.goal_y) - longint'(b.pose_y));
        hit = 0; best = 0;
        r = '0;
        for (int i = 0; i < NSAMP; i++)
        begin
            v = vlo + ((vhi - vlo) * i) / (NSAMP - 1);
            need = (5 * longint'(v) * v) / 98304 + v;
            if (need >= longint'({32'd0, b.obstacle_range})) continue;
            for (int j = 0; j < NSAMP; j++)
            begin
                w = wlo + ((whi - wlo) * j) / (NSAMP - 1);
                err = dir - int'(b.pose_heading) - int'(fdiv2(w, 3));
                while (err > PI_Q13) err -= TWO_PI_Q13;
                while (err < -PI_Q13) err += TWO_PI_Q13;
                if (err < 0) err = -err;
                score = 3 * longint'(v) - 80 * longint'(err);
                if (!hit || score > best)
                begin
                    hit = 1; best = score;
                    r.cmd_linear = v[14:0];
                    r.cmd_angular = w[15:0];
                end
            end
        end
        r.found = hit;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t e;
        if (!rst_n)
        begin
            lin_limit  <= MAX_LIN_RST;
            turn_limit <= MAX_TURN_RST;
            cmd_q.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (in_valid && in_ready) cmd_q.push_back(pick_command(in_data));
            if (out_valid && out_ready)
            begin
                if (cmd_q.size() == 0) report("unexpected beat", 0, 0);
                else
                begin
                    e = cmd_q.pop_front();
                    if (out_data.cmd_linear !== e.cmd_linear)
                        report("cmd_linear", out_data.cmd_linear, e.cmd_linear);
                    if (out_data.cmd_angular !== e.cmd_angular)
                        report("cmd_angular", out_data.cmd_angular, e.cmd_angular);
                    if (out_data.found !== e.found)
                        report("found", out_data.found, e.found);
                end
            end
            pending = cmd_q.size();
            if (cfg_we)
            begin
                if (cfg_addr == CFG_MAX_LINEAR) lin_limit <= cfg_data;
                else if (cfg_addr == CFG_MAX_TURN) turn_limit <= cfg_data;
            end
        end
    end
endmodule

>>> bench/dynamic_window_velocity_select_tb.sv
// ----------------------------------------------------------------------------
// dynamic_window_velocity_select_tb
// Drives directed and random pose/goal beats through the velocity selector
// under several speed-limit settings and idle patterns; a checker predicts.
// ----------------------------------------------------------------------------
module dynamic_window_velocity_select_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dwvs_pkg::*;

    localparam int DRAIN = CORDIC_STEPS_DEF + 20;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    in_beat_t in_data = '0;
    logic out_valid;
    logic out_ready = 0;
    out_beat_t out_data;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [14:0] cfg_data = '0;
    int errors, pending;
    int send_idle = 0;   // percent of cycles the sender holds off
    int recv_stall = 0;  // percent of cycles the receiver stalls

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    dynamic_window_velocity_select dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    dwvs_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    // receiver: random stalls per current phase
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall);

    // one beat: optional idle gap, then hold valid until accepted
    task automatic send_beat(in_beat_t b);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // wait until every expected command arrived, then let the pipe settle
    task automatic drain_out();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_limit(cfg_idx_t idx, logic [14:0] val);
        cfg_we   <= 1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(40000) * (($urandom_range(1)) ? 1 : -1);
            default: return int'($urandom_range(20 << 16)) - (10 << 16);
        endcase
    endfunction

    // mostly realistic scenes, some full-range noise
    function automatic in_beat_t rand_scene();
        in_beat_t b;
        b.pose_x = rand_pos();
        b.pose_y = rand_pos();
        b.goal_x = ($urandom_range(9) == 0) ? b.pose_x : rand_pos();
        b.goal_y = ($urandom_range(9) == 0) ? b.pose_y : rand_pos();
        b.pose_heading = ($urandom_range(7) == 0) ? 16'($urandom)
                                                  : 16'(int'($urandom_range(51472)) - 25736);
        case ($urandom_range(4))
            0: b.obstacle_range = $urandom;
            1: b.obstacle_range = $urandom_range(3);
            default: b.obstacle_range = $urandom_range(80000);
        endcase
        b.cur_linear  = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(24000));
        b.cur_angular = 16'($urandom);
        return b;
    endfunction

    task automatic directed();
        in_beat_t b;
        for (int k = 0; k < 20; k++)
        begin
            b = '0;
            b.goal_x = 32'sd65536;
            b.obstacle_range = 32'hFFFF_FFFF;
            case (k)
                0: b.goal_x = 0;                                   // goal on pose
                1: b.obstacle_range = 0;                           // all rejected
                2: begin b.pose_x = 32'h7FFF_FFFF; b.goal_x = 32'h8000_0000; end
                3: begin b.pose_y = 32'h8000_0000; b.goal_y = 32'h7FFF_FFFF; end
                4: b.cur_linear = 16'sh8000;                       // far below zero
                5: b.cur_linear = 16'sh7FFF;                       // above the limit
                6: b.cur_angular = 16'sh8000;
                7: b.cur_angular = 16'sh7FFF;
                8: b.pose_heading = 16'sh7FFF;                     // beyond pi
                9: b.pose_heading = 16'sh8000;
                10: b.pose_heading = 16'sd25736;
                11: b.pose_heading = -16'sd25736;
                12: begin b.goal_x = -32'sd65536; b.goal_y = 0; end
                13: begin b.goal_x = -32'sd65536; b.goal_y = -32'sd1; end
                14: begin b.goal_x = 0; b.goal_y = -32'sd65536; end
                15: begin b.obstacle_range = 32'd20000; b.cur_linear = 16'sd18000; end
                16: b.obstacle_range = 32'd1;
                17: begin b.pose_x = 32'hFFFF_FFFF; b.pose_y = 32'hFFFF_FFFF; end
                18: begin b.goal_x = 32'h5555_5555; b.goal_y = 32'hAAAA_AAAA; end
                default: begin b.cur_linear = 16'sd9830; b.cur_angular = -16'sd1; end
            endcase
            send_beat(b);
        end
    endtask

    initial
    begin
        logic [14:0] lin_set[6];
        logic [14:0] turn_set[6];
        lin_set  = '{MAX_LIN_RST, 15'd0, 15'h7FFF, 15'd1000, 15'h5555, 15'h2AAA};
        turn_set = '{MAX_TURN_RST, 15'h7FFF, 15'd0, 15'd5000, 15'h2AAA, 15'h5555};
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        directed();
        drain_out();
        for (int ph = 0; ph < 6; ph++)
        begin
            write_limit(CFG_MAX_LINEAR, lin_set[ph]);
            write_limit(CFG_MAX_TURN, turn_set[ph]);
            // idle mix rotates: none, sender, receiver, both
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 65; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 65; end
                default: begin send_idle = 32; recv_stall = 32; end
            endcase
            for (int n = 0; n < 305; n++)
            begin
                send_beat(rand_scene());
                if (n == 150)
                begin
                    // hold off until the pipe is empty, then resume
                    in_valid <= 0;
                    @(posedge clk);
                    while (pending != 0) @(posedge clk);
                end
            end
            drain_out();
        end
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end
endmodule
